@@ design/hierarchical_timer_wheel_top_macros.svh @@
// assertion helpers for the timer wheel, clocked on clk and idle during reset
`ifndef HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH
`define HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH

// property must hold at every clock edge out of reset
`define HTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true out of reset
`define HTW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/htw_pkg.sv @@
`default_nettype none

package htw_pkg;

    localparam int NEAR_BITS_DEF    = 8;
    localparam int LEVEL_BITS_DEF   = 6;
    localparam int POOL_ENTRIES_DEF = 64;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic STATUS_FIRED = 1'b0;
    localparam logic STATUS_FULL  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [30:0]        delay;
        logic [31:0]        owner_handle;
        logic signed [31:0] session_id;
    } req_t;

    typedef struct packed {
        logic [31:0]        out_handle;
        logic signed [31:0] out_session;
        logic               status;
        logic               last;
    } rsp_t;

    // read enable and per-field write enables of one memory
    typedef struct packed {
        logic re;
        logic we_hi;
        logic we_lo;
    } mem_ctl_t;

endpackage

`default_nettype wire

@@ design/hierarchical_timer_wheel_top.sv @@
// Hierarchical timer wheel with a pool of timer nodes.
// Request channel req_data/req_valid/req_stall: an add places a timer due after delay
// ticks, a tick advances time by one and fires what falls due.
// Result channel rsp_data/rsp_valid/rsp_stall: one result per fired timer, one for an
// add with zero delay or a full pool; last marks the final result of a request.
// Adds that store a timer give no result; a node that comes off the free list is read from
// node memory first, then the node is written, its bucket read and the timer linked. An
// add that answers at once passes its result to the output through the flush state. A tick
// fires the current slot, advances time, cascades a due level bucket and fires the new slot.
// Results leave through an output register with one more result held behind it, so
// a stalled receiver holds the walk only when both are full.
// After reset the bucket memory is swept to empty, one bucket a cycle, over all
// 2^NEAR_BITS + 4*2^LEVEL_BITS buckets (512 by default); req_stall stays high meanwhile.
// A fully free pool, time zero and empty buckets follow reset.
`default_nettype none

`include "hierarchical_timer_wheel_top_macros.svh"

module hierarchical_timer_wheel_top
    import htw_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int NEAR_BITS    = NEAR_BITS_DEF,
    parameter int LEVEL_BITS   = LEVEL_BITS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int NEAR_SLOTS = 1 << NEAR_BITS;
    localparam int BUCKETS    = NEAR_SLOTS + 4 * (1 << LEVEL_BITS);
    localparam int BW         = $clog2(BUCKETS);
    localparam int IW         = $clog2(POOL_ENTRIES);
    localparam int PW         = $clog2(POOL_ENTRIES + 1);
    localparam int NW         = 96 + PW;
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_ADD_POP    = 4'd2;
    localparam logic [3:0] S_ADD_WR     = 4'd3;
    localparam logic [3:0] S_APP        = 4'd4;
    localparam logic [3:0] S_FIRE_START = 4'd5;
    localparam logic [3:0] S_FIRE_HEAD  = 4'd6;
    localparam logic [3:0] S_FIRE_NODE  = 4'd7;
    localparam logic [3:0] S_ADVANCE    = 4'd8;
    localparam logic [3:0] S_CASC_HEAD  = 4'd9;
    localparam logic [3:0] S_CASC_NODE  = 4'd10;
    localparam logic [3:0] S_FLUSH      = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [PW-1:0] nxt_reg, nxt_next;
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [31:0]   now_reg, now_next;
    logic          phase_reg, phase_next;
    logic          casc_mode_reg, casc_mode_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          pend_reg, pend_next;
    rsp_t          out_reg, out_next;
    req_t          req_reg;

    mem_ctl_t         b_ctl, n_ctl;
    logic [BW-1:0]    b_raddr, b_waddr;
    logic [PW+IW-1:0] b_wdata, b_rdata;
    logic [IW-1:0]    n_raddr, n_waddr;
    logic [NW-1:0]    n_wdata, n_rdata;

    logic [PW-1:0]      b_head;
    logic [IW-1:0]      b_tail;
    logic [31:0]        n_expire;
    logic [31:0]        n_owner;
    logic signed [31:0] n_session;
    logic [PW-1:0]      n_next;

    logic [31:0]   add_expire;
    logic [31:0]   place_expire;
    logic [BW-1:0] place_bucket;
    logic          casc_valid;
    logic [BW-1:0] casc_bucket;
    logic          out_free;
    logic          accept;

    assign b_head    = b_rdata[PW+IW-1:IW];
    assign b_tail    = b_rdata[IW-1:0];
    assign n_expire  = n_rdata[NW-1 -: 32];
    assign n_owner   = n_rdata[NW-33 -: 32];
    assign n_session = n_rdata[NW-65 -: 32];
    assign n_next    = n_rdata[PW-1:0];

    assign add_expire   = now_reg + {1'b0, req_reg.delay};
    assign place_expire = (state_reg == S_ADD_WR) ? add_expire : n_expire;
    assign out_free     = !out_valid_reg || !rsp_stall;
    assign req_stall    = (state_reg != S_IDLE);
    assign accept       = req_valid && !req_stall;
    assign rsp_valid    = out_valid_reg;
    assign rsp_data     = out_reg;

    htw_ram #(
        .DEPTH    (BUCKETS),
        .WIDTH    (PW + IW),
        .LO_WIDTH (IW)
    ) u_bucket_ram (
        .clk   (clk),
        .ctl   (b_ctl),
        .raddr (b_raddr),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .rdata (b_rdata)
    );

    htw_ram #(
        .DEPTH    (POOL_ENTRIES),
        .WIDTH    (NW),
        .LO_WIDTH (PW)
    ) u_node_ram (
        .clk   (clk),
        .ctl   (n_ctl),
        .raddr (n_raddr),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .rdata (n_rdata)
    );

    htw_index #(
        .NEAR_BITS  (NEAR_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_index (
        .expire       (place_expire),
        .now          (now_reg),
        .place_bucket (place_bucket),
        .casc_valid   (casc_valid),
        .casc_bucket  (casc_bucket)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        now_next        = now_reg;
        phase_next      = phase_reg;
        casc_mode_next  = casc_mode_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;
        b_ctl           = '0;
        b_raddr         = bkt_reg;
        b_waddr         = bkt_reg;
        b_wdata         = {NIL, cur_reg};
        n_ctl           = '0;
        n_raddr         = cur_reg;
        n_waddr         = cur_reg;
        n_wdata         = {add_expire, req_reg.owner_handle, req_reg.session_id, NIL};

        unique case (state_reg)
            S_CLEAR:
            begin
                b_ctl.we_hi = 1'b1;
                b_waddr     = clr_reg;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + BW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.opcode == OP_TICK)
                    begin
                        phase_next = 1'b0;
                        state_next = S_FIRE_START;
                    end
                    else if (req_data.delay == 31'd0 ||
                             (free_head_reg == NIL && fresh_reg == PW'(0)))
                    begin
                        pend_next.out_handle  = req_data.owner_handle;
                        pend_next.out_session = req_data.session_id;
                        pend_next.status      = (req_data.delay == 31'd0) ?
                                                STATUS_FIRED : STATUS_FULL;
                        pend_next.last        = 1'b0;
                        pend_valid_next       = 1'b1;
                        state_next            = S_FLUSH;
                    end
                    else if (free_head_reg < NIL)
                    begin
                        cur_next   = free_head_reg[IW-1:0];
                        n_ctl.re   = 1'b1;
                        n_raddr    = free_head_reg[IW-1:0];
                        state_next = S_ADD_POP;
                    end
                    else
                    begin
                        fresh_next = fresh_reg - PW'(1);
                        cur_next   = fresh_next[IW-1:0];
                        state_next = S_ADD_WR;
                    end
                end
            end
            S_ADD_POP:
            begin
                free_head_next = n_next;
                state_next     = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                n_ctl.we_hi    = 1'b1;
                n_ctl.we_lo    = 1'b1;
                b_ctl.re       = 1'b1;
                b_raddr        = place_bucket;
                bkt_next       = place_bucket;
                casc_mode_next = 1'b0;
                state_next     = S_APP;
            end
            S_APP:
            begin
                b_wdata = {PW'(cur_reg), cur_reg};
                if (b_head < NIL)
                begin
                    b_ctl.we_lo = 1'b1;
                    n_ctl.we_lo = 1'b1;
                    n_waddr     = b_tail;
                    n_wdata     = {32'd0, 32'd0, 32'd0, PW'(cur_reg)};
                end
                else
                begin
                    b_ctl.we_hi = 1'b1;
                    b_ctl.we_lo = 1'b1;
                end
                if (!casc_mode_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (nxt_reg < NIL)
                begin
                    n_ctl.re   = 1'b1;
                    n_raddr    = nxt_reg[IW-1:0];
                    cur_next   = nxt_reg[IW-1:0];
                    state_next = S_CASC_NODE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_FIRE_START;
                end
            end
            S_FIRE_START:
            begin
                b_ctl.re   = 1'b1;
                b_raddr    = BW'(now_reg[NEAR_BITS-1:0]);
                bkt_next   = BW'(now_reg[NEAR_BITS-1:0]);
                state_next = S_FIRE_HEAD;
            end
            S_FIRE_HEAD:
            begin
                b_ctl.we_hi = 1'b1;
                if (b_head < NIL)
                begin
                    n_ctl.re   = 1'b1;
                    n_raddr    = b_head[IW-1:0];
                    cur_next   = b_head[IW-1:0];
                    state_next = S_FIRE_NODE;
                end
                else if (!phase_reg)
                begin
                    now_next   = now_reg + 32'd1;
                    state_next = S_ADVANCE;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FIRE_NODE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_next.last  = 1'b0;
                    end
                    pend_next.out_handle  = n_owner;
                    pend_next.out_session = n_session;
                    pend_next.status      = STATUS_FIRED;
                    pend_next.last        = 1'b0;
                    pend_valid_next       = 1'b1;
                    // freed node goes on top of the free list
                    n_ctl.we_lo    = 1'b1;
                    n_wdata        = {32'd0, 32'd0, 32'd0, free_head_reg};
                    free_head_next = PW'(cur_reg);
                    if (n_next < NIL)
                    begin
                        n_ctl.re = 1'b1;
                        n_raddr  = n_next[IW-1:0];
                        cur_next = n_next[IW-1:0];
                    end
                    else if (!phase_reg)
                    begin
                        now_next   = now_reg + 32'd1;
                        state_next = S_ADVANCE;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_ADVANCE:
            begin
                if (casc_valid)
                begin
                    b_ctl.re   = 1'b1;
                    b_raddr    = casc_bucket;
                    bkt_next   = casc_bucket;
                    state_next = S_CASC_HEAD;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_FIRE_START;
                end
            end
            S_CASC_HEAD:
            begin
                b_ctl.we_hi = 1'b1;
                if (b_head < NIL)
                begin
                    n_ctl.re   = 1'b1;
                    n_raddr    = b_head[IW-1:0];
                    cur_next   = b_head[IW-1:0];
                    state_next = S_CASC_NODE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_FIRE_START;
                end
            end
            S_CASC_NODE:
            begin
                nxt_next       = n_next;
                n_ctl.we_lo    = 1'b1;
                n_wdata        = {32'd0, 32'd0, 32'd0, NIL};
                b_ctl.re       = 1'b1;
                b_raddr        = place_bucket;
                bkt_next       = place_bucket;
                casc_mode_next = 1'b1;
                state_next     = S_APP;
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            bkt_reg        <= '0;
            cur_reg        <= '0;
            nxt_reg        <= NIL;
            free_head_reg  <= NIL;
            fresh_reg      <= PW'(POOL_ENTRIES);
            now_reg        <= 32'd0;
            phase_reg      <= 1'b0;
            casc_mode_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            bkt_reg        <= bkt_next;
            cur_reg        <= cur_next;
            nxt_reg        <= nxt_next;
            free_head_reg  <= free_head_next;
            fresh_reg      <= fresh_next;
            now_reg        <= now_next;
            phase_reg      <= phase_next;
            casc_mode_reg  <= casc_mode_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (accept)
        begin
            req_reg <= req_data;
        end
    end

    `HTW_NEVER(a_free_push_self, state_reg == S_FIRE_NODE && n_ctl.we_lo && free_head_reg == PW'(cur_reg), "freed node pushed onto itself")
    `HTW_ASSERT(a_idle_no_pend, state_reg == S_IDLE |-> !pend_valid_reg, "held result left behind at idle")
    `HTW_ASSERT(a_fresh_only_idle, fresh_reg != $past(fresh_reg) |-> $past(state_reg) == S_IDLE, "fresh node count moved outside an add")

endmodule

`default_nettype wire

@@ design/htw_ram.sv @@
`default_nettype none

module htw_ram
    import htw_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int WIDTH    = 16,
    parameter int LO_WIDTH = 8
)(
    input  wire logic                     clk,
    input  wire mem_ctl_t                 ctl,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we_hi)
        begin
            mem[waddr][WIDTH-1:LO_WIDTH] <= wdata[WIDTH-1:LO_WIDTH];
        end
        if (ctl.we_lo)
        begin
            mem[waddr][LO_WIDTH-1:0] <= wdata[LO_WIDTH-1:0];
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/htw_index.sv @@
`default_nettype none

module htw_index
    import htw_pkg::*;
#(
    parameter int NEAR_BITS  = NEAR_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)(
    input  wire logic [31:0] expire,
    input  wire logic [31:0] now,
    output logic [$clog2((1 << NEAR_BITS) + 4 * (1 << LEVEL_BITS))-1:0] place_bucket,
    output logic                                                         casc_valid,
    output logic [$clog2((1 << NEAR_BITS) + 4 * (1 << LEVEL_BITS))-1:0] casc_bucket
);

    localparam logic [31:0] NEAR_SLOTS  = 32'(1) << NEAR_BITS;
    localparam logic [31:0] LEVEL_SLOTS = 32'(1) << LEVEL_BITS;
    localparam logic [31:0] NEAR_MASK   = NEAR_SLOTS - 32'd1;
    localparam logic [31:0] LEVEL_MASK  = LEVEL_SLOTS - 32'd1;
    localparam int          BW = $clog2((1 << NEAR_BITS) + 4 * (1 << LEVEL_BITS));

    logic [31:0] diff;
    logic [1:0]  lvl;
    logic [31:0] slot;
    logic [31:0] pb;
    logic [31:0] cb;
    logic [31:0] idx;
    logic [31:0] low_mask;
    logic        done;

    // lowest level whose span covers every differing bit
    always_comb
    begin
        diff = expire ^ now;
        lvl  = 2'd3;
        for (int l = 2; l >= 0; l--)
        begin
            if ((diff >> (NEAR_BITS + (l + 1) * LEVEL_BITS)) == 32'd0)
            begin
                lvl = 2'(l);
            end
        end
        slot = (expire >> (NEAR_BITS + int'(lvl) * LEVEL_BITS)) & LEVEL_MASK;
        if ((diff >> NEAR_BITS) == 32'd0)
        begin
            pb = expire & NEAR_MASK;
        end
        else
        begin
            pb = NEAR_SLOTS + 32'(lvl) * LEVEL_SLOTS + slot;
        end
        place_bucket = pb[BW-1:0];
    end

    // level bucket that comes due at this time value
    always_comb
    begin
        done       = 1'b0;
        casc_valid = 1'b0;
        cb         = 32'd0;
        idx        = 32'd0;
        low_mask   = 32'd0;
        if (now == 32'd0)
        begin
            casc_valid = 1'b1;
            cb         = NEAR_SLOTS + 32'd3 * LEVEL_SLOTS;
        end
        else
        begin
            for (int l = 0; l < 4; l++)
            begin
                low_mask = (32'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 32'd1;
                idx      = (now >> (NEAR_BITS + l * LEVEL_BITS)) & LEVEL_MASK;
                if (!done)
                begin
                    if ((now & low_mask) != 32'd0)
                    begin
                        done = 1'b1;
                    end
                    else if (idx != 32'd0)
                    begin
                        casc_valid = 1'b1;
                        cb         = NEAR_SLOTS + 32'(l) * LEVEL_SLOTS + idx;
                        done       = 1'b1;
                    end
                end
            end
        end
        casc_bucket = cb[BW-1:0];
    end

endmodule

`default_nettype wire

@@ test/hierarchical_timer_wheel_top_tb.sv @@
`timescale 1ns / 1ps

module hierarchical_timer_wheel_top_tb;
    import htw_pkg::*;

    localparam int POOL      = 64;
    localparam int NEAR_W    = 8;
    localparam int LEVEL_W   = 6;
    localparam int NEAR_CNT  = 1 << NEAR_W;
    localparam int BUCKET_CNT = NEAR_CNT + 4 * (1 << LEVEL_W);
    localparam logic [6:0] NIL = 7'(POOL);
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    hierarchical_timer_wheel_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // wheel state mirror
    logic [31:0] wheel_now;
    logic [6:0]  head_of[BUCKET_CNT];
    logic [5:0]  tail_of[BUCKET_CNT];
    logic [31:0] timer_expire[POOL];
    logic [31:0] timer_owner[POOL];
    logic [31:0] timer_session[POOL];
    logic [6:0]  timer_next[POOL];
    logic [5:0]  free_nodes[POOL];
    int          free_cnt;

    rsp_t expected_fires[$];
    int   error_cnt;
    logic hold_results;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void link_timer(int b, logic [5:0] n);
        timer_next[n] = NIL;
        if (head_of[b] == NIL)
            head_of[b] = {1'b0, n};
        else
            timer_next[tail_of[b]] = {1'b0, n};
        tail_of[b] = n;
    endfunction

    function automatic void file_timer(logic [5:0] n);
        logic [31:0] e;
        logic [31:0] diff;
        int lvl;
        e = timer_expire[n];
        diff = e ^ wheel_now;
        if ((diff >> NEAR_W) == 0) begin
            link_timer(int'(e[NEAR_W-1:0]), n);
            return;
        end
        for (lvl = 0; lvl < 3; lvl++)
            if ((diff >> (NEAR_W + (lvl + 1) * LEVEL_W)) == 0)
                break;
        link_timer(NEAR_CNT + lvl * 64 + int'((e >> (NEAR_W + lvl * LEVEL_W)) & 63), n);
    endfunction

    function automatic void cascade_bucket(int lvl, int slot);
        int b;
        logic [6:0] cur;
        logic [6:0] nxt;
        b = NEAR_CNT + lvl * 64 + slot;
        cur = head_of[b];
        head_of[b] = NIL;
        while (cur != NIL) begin
            nxt = timer_next[cur[5:0]];
            file_timer(cur[5:0]);
            cur = nxt;
        end
    endfunction

    function automatic void fire_due(ref rsp_t fired[$]);
        int b;
        logic [6:0] cur;
        rsp_t r;
        b = int'(wheel_now[NEAR_W-1:0]);
        cur = head_of[b];
        head_of[b] = NIL;
        while (cur != NIL) begin
            r.out_handle = timer_owner[cur[5:0]];
            r.out_session = timer_session[cur[5:0]];
            r.status = STATUS_FIRED;
            r.last = 1'b0;
            fired.push_back(r);
            free_nodes[free_cnt] = cur[5:0];
            free_cnt++;
            cur = timer_next[cur[5:0]];
        end
    endfunction

    function automatic void advance_time();
        int lvl;
        int bits;
        int idx;
        wheel_now = wheel_now + 1;
        if (wheel_now == 0) begin
            cascade_bucket(3, 0);
            return;
        end
        for (lvl = 0; lvl < 4; lvl++) begin
            bits = NEAR_W + lvl * LEVEL_W;
            if ((wheel_now & ((32'd1 << bits) - 1)) != 0)
                break;
            idx = int'((wheel_now >> bits) & 63);
            if (idx != 0) begin
                cascade_bucket(lvl, idx);
                break;
            end
        end
    endfunction

    function automatic void predict_request(req_t q);
        rsp_t fired[$];
        rsp_t r;
        logic [5:0] n;
        if (q.opcode == OP_ADD) begin
            if (q.delay == 0 || free_cnt == 0) begin
                r.out_handle = q.owner_handle;
                r.out_session = q.session_id;
                r.status = (q.delay == 0) ? STATUS_FIRED : STATUS_FULL;
                r.last = 1'b1;
                expected_fires.push_back(r);
                return;
            end
            free_cnt--;
            n = free_nodes[free_cnt];
            timer_expire[n] = wheel_now + {1'b0, q.delay};
            timer_owner[n] = q.owner_handle;
            timer_session[n] = q.session_id;
            file_timer(n);
            return;
        end
        fire_due(fired);
        advance_time();
        fire_due(fired);
        if (fired.size() > 0)
            fired[fired.size() - 1].last = 1'b1;
        foreach (fired[i])
            expected_fires.push_back(fired[i]);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_cnt++;
    endtask

    // sends one request, leaves valid high afterward
    task automatic send_request(logic op, logic [30:0] dly, logic [31:0] h, logic [31:0] s);
        @(negedge clk);
        req_valid = 1'b1;
        req_data.opcode = op;
        req_data.delay = dly;
        req_data.owner_handle = h;
        req_data.session_id = s;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        predict_request(req_data);
    endtask

    task automatic pause_sender(int n);
        @(negedge clk);
        req_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic add_timer(logic [30:0] dly);
        send_request(OP_ADD, dly, $urandom, $urandom);
    endtask

    task automatic tick();
        send_request(OP_TICK, 31'($urandom), $urandom, $urandom);
    endtask

    task automatic test_zero_delay();
        send_request(OP_ADD, 31'd0, 32'h0, 32'h8000_0000);
        send_request(OP_ADD, 31'd0, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(OP_ADD, 31'd0, 32'h1234_5678, 32'hffff_ffff);
    endtask

    task automatic test_single_timers();
        add_timer(31'd1);
        add_timer(31'd2);
        add_timer(31'd2);
        add_timer(31'd255);
        add_timer(31'd256);
        add_timer(31'd300);
        add_timer(31'd20000);
        add_timer(31'h7fff_ffff);
        tick();
        tick();
        tick();
        pause_sender(3);
    endtask

    task automatic test_pool_full();
        while (free_cnt > 0)
            add_timer(31'd4);
        add_timer(31'd7);
        repeat (6) tick();
        pause_sender(2);
    endtask

    // receiver holds off while zero-delay adds pile up behind it
    task automatic test_backpressure();
        @(negedge clk);
        hold_results = 1'b1;
        repeat (20)
            add_timer(31'd0);
        pause_sender(1);
    endtask

    task automatic test_random(int count);
        int sent;
        int burst;
        int pick;
        logic [30:0] dly;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 48)
                    tick();
                else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        dly = 31'd0;
                    else if (pick < 7)
                        dly = 31'($urandom);
                    else if (pick < 25)
                        dly = 31'($urandom_range(1, 600));
                    else
                        dly = 31'($urandom_range(1, 40));
                    add_timer(dly);
                end
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(0, 6));
        end
    endtask

    // result checker
    initial begin
        rsp_t want;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall) begin
                if (expected_fires.size() == 0) begin
                    report_mismatch("unexpected handle", rsp_data.out_handle, 32'd0);
                end else begin
                    want = expected_fires.pop_front();
                    if (rsp_data.out_handle !== want.out_handle)
                        report_mismatch("handle", rsp_data.out_handle, want.out_handle);
                    if (rsp_data.out_session !== want.out_session)
                        report_mismatch("session", rsp_data.out_session, want.out_session);
                    if (rsp_data.status !== want.status)
                        report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
                    if (rsp_data.last !== want.last)
                        report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        int mode;
        int left;
        rsp_stall = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge clk);
            if (hold_results) begin
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0: rsp_stall = 1'b0;
                1: rsp_stall = ($urandom_range(0, 9) < 3);
                default: rsp_stall = ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // watchdog on cycles with no handshake
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        hold_results = 1'b0;
        error_cnt = 0;
        wheel_now = '0;
        for (int i = 0; i < BUCKET_CNT; i++) begin
            head_of[i] = NIL;
            tail_of[i] = '0;
        end
        for (int i = 0; i < POOL; i++)
            free_nodes[i] = 6'(i);
        free_cnt = POOL;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_delay();
        test_single_timers();
        test_pool_full();
        test_backpressure();
        test_random(360);

        pause_sender(1);
        while (expected_fires.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
